FILE: hw/rtl/gma_pkg.sv
// Shared types and constants for the group mean accumulator.
`timescale 1ns / 1ps

package gma_pkg;

    localparam int DEF_MAX_BINS = 64;
    localparam int GROUPS_W     = 7;
    localparam int ID_W         = 8;
    localparam int VAL_W        = 32;
    localparam int SUM_W        = 48;
    localparam int CNT_W        = 24;
    localparam int KIND_W       = 2;
    localparam int DIV_STEPS    = SUM_W;

    localparam logic [GROUPS_W-1:0] GROUPS_RESET = GROUPS_W'(64);

    typedef enum logic [0:0] {
        CMD_ADD    = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NA   = 2'd0,
        KIND_NAN  = 2'd1,
        KIND_MEAN = 2'd2
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic  accept;
        logic  rd;
        logic  rd_walk;
        logic  add_wr;
        logic  div_start;
        logic  load_res;
        kind_t res_kind;
        logic  walk_next;
        logic  clear;
    } gma_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic n_zero;
        logic walk_last;
        logic seen;
        logic count_zero;
        logic div_done;
    } gma_stat_t;

endpackage

FILE: hw/rtl/gma_divider.sv
// Bit-serial restoring divider: signed 48-bit sum over unsigned 24-bit count, saturated to 32 bits.
`timescale 1ns / 1ps

module gma_divider
    import gma_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [VAL_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;

    logic [CNT_W:0]    rem_sh;
    logic              ge;
    logic [CNT_W:0]    rem_diff;
    logic [CNT_W-1:0]  rem_next;
    logic [SUM_W-1:0]  quo_next;
    logic              ovf;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_diff = rem_sh - {1'b0, den_reg};
        rem_next = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            quo_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        ovf = quo_reg[SUM_W-1:VAL_W-1] != '0;
        if (neg_reg)
            quotient = ovf ? VAL_MIN : VAL_W'(-quo_reg[VAL_W-1:0]);
        else
            quotient = ovf ? VAL_MAX : VAL_W'(quo_reg[VAL_W-1:0]);
    end

    assign done = done_reg;

endmodule

FILE: hw/rtl/gma_datapath.sv
// Bin store, seen flags, saturating accumulate, config register and result registers.
`timescale 1ns / 1ps

module gma_datapath
    import gma_pkg::*;
#(
    parameter int MAX_BINS = DEF_MAX_BINS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  gma_cmd_t                ctl,
    output gma_stat_t               stat,
    input  logic [ID_W-1:0]         group_id,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic                    sample_missing,
    input  logic                    cfg_write,
    input  logic [GROUPS_W-1:0]     cfg_data,
    output logic [GROUPS_W-1:0]     bin_number,
    output logic signed [VAL_W-1:0] mean_value,
    output logic [KIND_W-1:0]       result_kind,
    output logic                    last_result
);

    localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
    } bin_entry_t;

    bin_entry_t              mem [MAX_BINS];
    bin_entry_t              rd_data_reg;
    logic [MAX_BINS-1:0]     seen_reg;
    logic [GROUPS_W-1:0]     groups_reg;
    logic [BIN_W-1:0]        walk_reg;
    logic [BIN_W-1:0]        idx_reg;
    logic                    hit_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                    miss_reg;

    logic [GROUPS_W-1:0]     n_bins;
    logic                    in_hit;
    logic [ID_W-1:0]         id_m1;
    logic [BIN_W-1:0]        rd_addr;
    bin_entry_t              base;
    bin_entry_t              wr_entry;
    logic signed [SUM_W:0]   sum_ext;
    logic signed [VAL_W-1:0] div_q;
    logic                    div_done;

    always_comb
    begin
        n_bins  = (groups_reg > GROUPS_W'(MAX_BINS)) ? GROUPS_W'(MAX_BINS) : groups_reg;
        in_hit  = (group_id != '0) && (group_id <= ID_W'(n_bins));
        id_m1   = group_id - ID_W'(1);
        rd_addr = ctl.rd_walk ? walk_reg : (in_hit ? id_m1[BIN_W-1:0] : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            groups_reg <= GROUPS_RESET;
        else if (cfg_write)
            groups_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            idx_reg  <= id_m1[BIN_W-1:0];
            hit_reg  <= in_hit;
            val_reg  <= sample_value;
            miss_reg <= sample_missing;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            walk_reg <= '0;
        else if (ctl.accept)
            walk_reg <= '0;
        else if (ctl.walk_next)
            walk_reg <= walk_reg + BIN_W'(1);
    end

    // untouched entries read as zero through their seen flag
    always_comb
    begin
        base     = seen_reg[idx_reg] ? rd_data_reg : '0;
        sum_ext  = {base.sum[SUM_W-1], base.sum} + (SUM_W+1)'(val_reg);
        wr_entry = base;
        if (!miss_reg && (base.cnt != CNT_MAX))
        begin
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                wr_entry.sum = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
            else
                wr_entry.sum = sum_ext[SUM_W-1:0];
            wr_entry.cnt = base.cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.add_wr && hit_reg)
            mem[idx_reg] <= wr_entry;
        if (ctl.rd)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (ctl.clear)
            seen_reg <= '0;
        else if (ctl.add_wr && hit_reg)
            seen_reg[idx_reg] <= 1'b1;
    end

    gma_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (rd_data_reg.sum),
        .divisor  (rd_data_reg.cnt),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load_res)
        begin
            bin_number  <= GROUPS_W'(walk_reg) + GROUPS_W'(1);
            mean_value  <= (ctl.res_kind == KIND_MEAN) ? div_q : '0;
            result_kind <= ctl.res_kind;
            last_result <= stat.walk_last;
        end
    end

    always_comb
    begin
        stat.n_zero     = n_bins == '0;
        stat.walk_last  = (GROUPS_W'(walk_reg) + GROUPS_W'(1)) == n_bins;
        stat.seen       = seen_reg[walk_reg];
        stat.count_zero = rd_data_reg.cnt == '0;
        stat.div_done   = div_done;
    end

endmodule

FILE: hw/rtl/gma_ctrl.sv
// Controller state machine: add read-modify-write, finish walk, store clear.
`timescale 1ns / 1ps

module gma_ctrl
    import gma_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  cmd_t      cmd,
    input  gma_stat_t stat,
    output gma_cmd_t  ctl,
    output logic      busy,
    output logic      result_strobe
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_WR,
        S_FIN_RD,
        S_FIN_EVAL,
        S_FIN_DIV,
        S_FIN_NEXT,
        S_CLEAR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   strobe_reg;
    logic   strobe_next;

    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        ctl         = '0;
        ctl.res_kind = KIND_NA;
        case (state_reg)
            S_IDLE:
            begin
                ctl.rd = 1'b1;
                if (start)
                begin
                    ctl.accept = 1'b1;
                    if (cmd == CMD_FINISH)
                        state_next = stat.n_zero ? S_CLEAR : S_FIN_RD;
                    else
                        state_next = S_ADD_WR;
                end
            end
            S_ADD_WR:
            begin
                ctl.add_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_FIN_RD:
            begin
                ctl.rd      = 1'b1;
                ctl.rd_walk = 1'b1;
                state_next  = S_FIN_EVAL;
            end
            S_FIN_EVAL:
            begin
                if (!stat.seen)
                begin
                    ctl.load_res = 1'b1;
                    ctl.res_kind = KIND_NA;
                    strobe_next  = 1'b1;
                    state_next   = S_FIN_NEXT;
                end
                else if (stat.count_zero)
                begin
                    ctl.load_res = 1'b1;
                    ctl.res_kind = KIND_NAN;
                    strobe_next  = 1'b1;
                    state_next   = S_FIN_NEXT;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_FIN_DIV;
                end
            end
            S_FIN_DIV:
            begin
                if (stat.div_done)
                begin
                    ctl.load_res = 1'b1;
                    ctl.res_kind = KIND_MEAN;
                    strobe_next  = 1'b1;
                    state_next   = S_FIN_NEXT;
                end
            end
            S_FIN_NEXT:
            begin
                if (stat.walk_last)
                    state_next = S_CLEAR;
                else
                begin
                    ctl.walk_next = 1'b1;
                    state_next    = S_FIN_RD;
                end
            end
            S_CLEAR:
            begin
                ctl.clear  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy          = state_reg != S_IDLE;
    assign result_strobe = strobe_reg;

endmodule

FILE: hw/rtl/group_mean_accumulator.sv
// Top level of the group mean accumulator.
//
// Commands are taken on start while busy is low. cmd add (0) puts one Q16.16
// sample into the bin named by the 1-based group_id; ids of zero or above the
// bins in use are dropped. An add keeps busy high for one cycle after the
// transfer (one read-modify-write of the bin memory). cmd finish (1) walks
// bins 1..n in order and puts one result on the result ports per bin, each
// for exactly one cycle with result_strobe high; last_result marks the final
// one. A bin with no hits or only missing samples skips the bit-serial
// divider (48 steps) that a mean needs. After the walk the clear state
// wipes the seen flags, then busy drops. The receiver cannot stall; results
// are simply strobed out. groups_in_use is written over the cfg channel
// (always ready); the user must write it only while idle, the block does
// not enforce this. Reset clears all bins at once through their seen flags
// and sets groups_in_use to 64; no clearing pass is needed.
`timescale 1ns / 1ps

module group_mean_accumulator
    import gma_pkg::*;
#(
    parameter int MAX_BINS = DEF_MAX_BINS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [0:0]              cmd,
    input  logic [ID_W-1:0]         group_id,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic                    sample_missing,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [GROUPS_W-1:0]     cfg_data,
    output logic                    result_strobe,
    output logic [GROUPS_W-1:0]     bin_number,
    output logic signed [VAL_W-1:0] mean_value,
    output logic [KIND_W-1:0]       result_kind,
    output logic                    last_result
);

    gma_cmd_t  ctl;
    gma_stat_t stat;
    logic      ctl_start;

    assign cfg_ready = 1'b1;
    assign ctl_start = start && !busy;

    gma_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (ctl_start),
        .cmd           (cmd_t'(cmd)),
        .stat          (stat),
        .ctl           (ctl),
        .busy          (busy),
        .result_strobe (result_strobe)
    );

    gma_datapath #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .group_id       (group_id),
        .sample_value   (sample_value),
        .sample_missing (sample_missing),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .bin_number     (bin_number),
        .mean_value     (mean_value),
        .result_kind    (result_kind),
        .last_result    (last_result)
    );

endmodule

FILE: hw/rtl/gma_checker.sv
// Port-level assertions for the group mean accumulator, bound to the top level.
`timescale 1ns / 1ps

module gma_checker
    import gma_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    result_strobe,
    input logic [GROUPS_W-1:0]     bin_number,
    input logic signed [VAL_W-1:0] mean_value,
    input logic [KIND_W-1:0]       result_kind,
    input logic                    last_result
);

    // results only come out during a finish walk
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe while idle");

    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (result_kind != KIND_MEAN)) |-> (mean_value == '0))
        else $error("mean not zero for NA/NaN result");

    a_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // the store clear follows the last result
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_result) |=> (busy && !result_strobe))
        else $error("no clear cycle after last result");

    a_bin_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (bin_number != '0))
        else $error("result with bin number zero");

endmodule

bind group_mean_accumulator gma_checker u_gma_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .bin_number    (bin_number),
    .mean_value    (mean_value),
    .result_kind   (result_kind),
    .last_result   (last_result)
);

FILE: tb/group_mean_checker.sv
// Checker for the group mean accumulator: tracks bin state and compares strobed results.
`timescale 1ns / 1ps

module group_mean_checker
    import gma_pkg::*;
#(
    parameter int MAX_BINS = DEF_MAX_BINS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [0:0]              cmd,
    input  logic [ID_W-1:0]         group_id,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic                    sample_missing,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [GROUPS_W-1:0]     cfg_data,
    input  logic                    result_strobe,
    input  logic [GROUPS_W-1:0]     bin_number,
    input  logic signed [VAL_W-1:0] mean_value,
    input  logic [KIND_W-1:0]       result_kind,
    input  logic                    last_result,
    output int                      fail_count,
    output int                      pending
);

    localparam longint SUM_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO  = -SUM_HI - 64'sd1;
    localparam longint MEAN_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint MEAN_LO = -MEAN_HI - 64'sd1;
    localparam logic [CNT_W-1:0] CNT_FULL = '1;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [GROUPS_W-1:0]     bin;
        logic signed [VAL_W-1:0] mean;
        kind_t                   kind;
        logic                    last;
    } bin_result_t;

    logic signed [SUM_W-1:0] bin_total [MAX_BINS];
    logic [CNT_W-1:0]        bin_tally [MAX_BINS];
    logic                    bin_hit   [MAX_BINS];
    logic [GROUPS_W-1:0]     groups_cfg;
    bin_result_t             mean_q [$];
    int                      errors;

    function automatic int bins_live();
        return (groups_cfg > MAX_BINS) ? MAX_BINS : int'(groups_cfg);
    endfunction

    task automatic clear_bins();
        for (int b = 0; b < MAX_BINS; b++)
        begin
            bin_total[b] = '0;
            bin_tally[b] = '0;
            bin_hit[b]   = 1'b0;
        end
    endtask

    task automatic add_sample(input logic [ID_W-1:0] id, input logic signed [VAL_W-1:0] val,
                              input logic miss);
        int     b;
        longint acc;
        longint inc;
        if (id >= 1 && id <= bins_live())
        begin
            b = int'(id) - 1;
            bin_hit[b] = 1'b1;
            if (!miss && bin_tally[b] != CNT_FULL)
            begin
                acc = bin_total[b];
                inc = val;
                acc = acc + inc;
                if (acc > SUM_HI)
                    acc = SUM_HI;
                if (acc < SUM_LO)
                    acc = SUM_LO;
                bin_total[b] = acc[SUM_W-1:0];
                bin_tally[b] = bin_tally[b] + 1'b1;
            end
        end
    endtask

    task automatic emit_means();
        int          n;
        longint      tot;
        longint      cnt;
        longint      m;
        bin_result_t r;
        n = bins_live();
        for (int b = 0; b < n; b++)
        begin
            r.bin  = GROUPS_W'(b + 1);
            r.mean = '0;
            r.last = (b + 1 == n);
            if (!bin_hit[b])
                r.kind = KIND_NA;
            else if (bin_tally[b] == '0)
                r.kind = KIND_NAN;
            else
            begin
                tot = bin_total[b];
                cnt = bin_tally[b];
                m = tot / cnt;
                if (m > MEAN_HI)
                    m = MEAN_HI;
                if (m < MEAN_LO)
                    m = MEAN_LO;
                r.mean = m[VAL_W-1:0];
                r.kind = KIND_MEAN;
            end
            mean_q.push_back(r);
        end
        clear_bins();
    endtask

    task automatic check_result();
        bin_result_t r;
        if (mean_q.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("%0t: unexpected result bin=%0d mean=%0d kind=%0d last=%0b",
                         $realtime, bin_number, mean_value, result_kind, last_result);
        end
        else
        begin
            r = mean_q.pop_front();
            if (bin_number !== r.bin || mean_value !== r.mean || result_kind !== r.kind
                || last_result !== r.last)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: result mismatch exp bin=%0d mean=%0d kind=%0d last=%0b, got bin=%0d mean=%0d kind=%0d last=%0b",
                             $realtime, r.bin, r.mean, r.kind, r.last,
                             bin_number, mean_value, result_kind, last_result);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_bins();
            groups_cfg = GROUPS_RESET;
            mean_q.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (result_strobe)
                check_result();
            if (cfg_valid && cfg_ready)
                groups_cfg = cfg_data;
            if (start && !busy)
            begin
                if (cmd == CMD_FINISH)
                    emit_means();
                else
                    add_sample(group_id, sample_value, sample_missing);
            end
            fail_count <= errors;
            pending <= mean_q.size();
        end
    end

endmodule

FILE: tb/group_mean_accumulator_tb.sv
// Testbench top for the group mean accumulator: stimulus, idle phases and verdict.
`timescale 1ns / 1ps

module group_mean_accumulator_tb
    import gma_pkg::*;
;

    localparam int LIMIT_CYCLES     = 5_000_000;
    localparam int SETTLE_CYCLES    = 60;
    localparam int BIG_ROUNDS       = 8;
    localparam int RANDOM_PER_PHASE = 40;
    localparam int PHASES           = 4;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    cmd_t                    cmd = CMD_ADD;
    logic [ID_W-1:0]         group_id = '0;
    logic signed [VAL_W-1:0] sample_value = '0;
    logic                    sample_missing = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [GROUPS_W-1:0]     cfg_data = '0;
    logic                    busy;
    logic                    cfg_ready;
    logic                    result_strobe;
    logic [GROUPS_W-1:0]     bin_number;
    logic signed [VAL_W-1:0] mean_value;
    logic [KIND_W-1:0]       result_kind;
    logic                    last_result;
    int                      fail_count;
    int                      pending;
    int                      cycles = 0;
    int                      idle_pct = 0;

    group_mean_accumulator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .group_id       (group_id),
        .sample_value   (sample_value),
        .sample_missing (sample_missing),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_strobe  (result_strobe),
        .bin_number     (bin_number),
        .mean_value     (mean_value),
        .result_kind    (result_kind),
        .last_result    (last_result)
    );

    group_mean_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .group_id       (group_id),
        .sample_value   (sample_value),
        .sample_missing (sample_missing),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_strobe  (result_strobe),
        .bin_number     (bin_number),
        .mean_value     (mean_value),
        .result_kind    (result_kind),
        .last_result    (last_result),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one command transfer, with random idle cycles ahead of it
    task automatic send(input cmd_t c, input logic [ID_W-1:0] id,
                        input logic signed [VAL_W-1:0] v, input logic miss);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            group_id <= ID_W'($urandom);
            sample_value <= $urandom;
            sample_missing <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        cmd <= c;
        group_id <= id;
        sample_value <= v;
        sample_missing <= miss;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_groups(input logic [GROUPS_W-1:0] g);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= g;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item(input int n_live);
        logic [ID_W-1:0]         id;
        logic signed [VAL_W-1:0] v;
        if ($urandom_range(0, 11) == 0)
            send(CMD_FINISH, ID_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
        else
        begin
            if (n_live > 0 && $urandom_range(0, 9) < 7)
                id = ID_W'($urandom_range(1, n_live));
            else
                id = ID_W'($urandom);
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1:
                begin
                    v = $urandom_range(0, 20000);
                    v = v - 10000;
                end
                2: v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
                default: v = $urandom & 32'h000F_FFFF;
            endcase
            send(CMD_ADD, id, v, $urandom_range(0, 4) == 0);
        end
    endtask

    initial
    begin
        int g;
        int n_live;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: 64 bins; truncation toward zero, NaN, ignored ids
        send(CMD_ADD, 1, VAL_MAX, 1'b0);
        send(CMD_ADD, 1, VAL_MIN, 1'b0);
        send(CMD_ADD, 2, -3, 1'b0);
        send(CMD_ADD, 2, -4, 1'b0);
        send(CMD_ADD, 3, 123, 1'b1);
        send(CMD_ADD, 64, 32'shFFFF_FFFF, 1'b0);
        send(CMD_ADD, 0, 77, 1'b0);
        send(CMD_ADD, 65, 77, 1'b0);
        send(CMD_ADD, 255, VAL_MAX, 1'b0);
        send(CMD_ADD, 4, 1000, 1'b1);
        send(CMD_ADD, 4, 32'sh0001_8000, 1'b0);
        send(CMD_FINISH, 8'hFF, VAL_MIN, 1'b1);
        send(CMD_FINISH, 0, 0, 1'b0);

        // finish clears bins beyond those in use
        send(CMD_ADD, 10, 5, 1'b0);
        write_groups(2);
        send(CMD_FINISH, 10, 5, 1'b0);
        write_groups(0);
        send(CMD_ADD, 1, 9, 1'b0);
        send(CMD_FINISH, 1, 9, 1'b0);
        write_groups(64);
        send(CMD_FINISH, 0, 0, 1'b0);

        // large sums of both signs, then step back toward zero
        write_groups(2);
        for (int i = 0; i < BIG_ROUNDS; i++)
        begin
            send(CMD_ADD, 1, VAL_MAX, 1'b0);
            send(CMD_ADD, 2, VAL_MIN, 1'b0);
        end
        send(CMD_ADD, 1, VAL_MIN, 1'b0);
        send(CMD_ADD, 2, VAL_MAX, 1'b0);
        send(CMD_FINISH, 2, 0, 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    g = 127;
                    idle_pct = 0;
                end
                1:
                begin
                    g = $urandom_range(2, 63);
                    idle_pct = 55;
                end
                2:
                begin
                    g = 64;
                    idle_pct = 0;
                end
                default:
                begin
                    g = $urandom_range(1, 8);
                    idle_pct = 33;
                end
            endcase
            write_groups(GROUPS_W'(g));
            n_live = (g > DEF_MAX_BINS) ? DEF_MAX_BINS : g;
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                random_item(n_live);
                if (i == RANDOM_PER_PHASE / 2)
                    drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
